FILE: hdl/fjot_pkg.sv
// Shared types for the flat object tokenizer: transfer payloads, result kinds,
// error codes and the command word passed from the parser to the emitter.
// No dependencies.
package fjot_pkg;

  // Default depth of the held whitespace store.
  localparam int unsigned WS_PENDING_DEPTH_DFLT = 32;

  // Depth of the command queue between the parser and the emitter.
  localparam int unsigned CMD_FIFO_DEPTH = 4;

  // Operation codes of an input item.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_KEY      = 3'd0,
    KIND_KEY_END  = 3'd1,
    KIND_VAL      = 3'd2,
    KIND_PAIR_END = 3'd3,
    KIND_ACCEPT   = 3'd4,
    KIND_REJECT   = 3'd5
  } kind_e;

  // Reject reasons.
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_BRACE       = 4'd1,
    ERR_QUOTE       = 4'd2,
    ERR_COLON       = 4'd3,
    ERR_COMMA_BRACE = 4'd4,
    ERR_OPEN_ESC    = 4'd5,
    ERR_BAD_ESC     = 4'd6,
    ERR_OPEN_STR    = 4'd7,
    ERR_TRAILING    = 4'd8,
    ERR_OVERFLOW    = 4'd9
  } err_e;

  // Commands for the emitter.
  typedef enum logic [1:0] {
    CMD_EMIT  = 2'd0,  // give one result, drop held whitespace
    CMD_HOLD  = 2'd1,  // store one whitespace byte, no result
    CMD_DRAIN = 2'd2   // give all held whitespace, then one value byte
  } cmd_e;

  // Input item.
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } fjot_in_t;

  // Result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    err_e       error_code;
    logic       last_of_run;
  } fjot_out_t;

  // Command word.
  typedef struct packed {
    cmd_e       op;
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
  } cmd_t;

endpackage

FILE: hdl/fjot_front.sv
// Parser front end: accepts input items, tracks the parse phase and turns each
// item into at most one command for the emitter. Depends on fjot_pkg.
module fjot_front #(
  parameter int unsigned WS_PENDING_DEPTH = fjot_pkg::WS_PENDING_DEPTH_DFLT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  fjot_pkg::fjot_in_t in_item_i,
  output logic             full,
  output logic             cmd_valid_o,
  output fjot_pkg::cmd_t   cmd_o,
  input  logic             cmd_full_i
);
  import fjot_pkg::*;

  localparam int unsigned CW = $clog2(WS_PENDING_DEPTH + 1);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    PH_START,
    PH_OPEN,
    PH_KEY,
    PH_KEY_ESC,
    PH_AFTER_KEY,
    PH_BEFORE_VAL,
    PH_VSTR,
    PH_VSTR_ESC,
    PH_AFTER_VAL,
    PH_BARE,
    PH_AFTER_COMMA,
    PH_CLOSED,
    PH_FAILED
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          ws;
  logic [7:0]    c;
  logic [8:0]    esc;

  function automatic logic is_ws(logic [7:0] b);
    is_ws = (b inside {[CH_TAB:CH_CR], CH_SPACE});
  endfunction

  // Top bit set marks an unsupported escape.
  function automatic logic [8:0] decode_escape(logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: decode_escape = {1'b0, b};
      8'h62:   decode_escape = {1'b0, CH_BS};
      8'h66:   decode_escape = {1'b0, CH_FF};
      8'h6E:   decode_escape = {1'b0, CH_LF};
      8'h72:   decode_escape = {1'b0, CH_CR};
      8'h74:   decode_escape = {1'b0, CH_TAB};
      default: decode_escape = {1'b1, 8'h00};
    endcase
  endfunction

  function automatic cmd_t mk(cmd_e op, kind_e k, logic [7:0] b, err_e e);
    cmd_t r;
    r.op   = op;
    r.kind = k;
    r.data = b;
    r.err  = e;
    mk = r;
  endfunction

  // The item is taken whenever the queue has room.
  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;
  assign c      = in_item_i.data_byte;
  assign ws     = is_ws(c);
  assign esc    = decode_escape(c);

  // Phase transitions and command generation.
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    cmd_valid_o = 1'b0;
    cmd_o       = mk(CMD_EMIT, KIND_KEY, 8'h00, ERR_NONE);
    if (accept) begin
      if (in_item_i.operation == OP_END) begin
        phase_d     = PH_START;
        cnt_d       = '0;
        cmd_valid_o = 1'b1;
        case (phase_q)
          PH_START, PH_CLOSED: cmd_o = mk(CMD_EMIT, KIND_ACCEPT, 8'h00, ERR_NONE);
          PH_OPEN, PH_AFTER_COMMA: cmd_o = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_QUOTE);
          PH_KEY, PH_VSTR: cmd_o = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_OPEN_STR);
          PH_KEY_ESC, PH_VSTR_ESC: cmd_o = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_OPEN_ESC);
          PH_AFTER_KEY: cmd_o = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_COLON);
          PH_BEFORE_VAL, PH_AFTER_VAL, PH_BARE: begin
            cmd_o = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_COMMA_BRACE);
          end
          default: cmd_valid_o = 1'b0;
        endcase
      end else begin
        case (phase_q)
          PH_START: begin
            if (!ws) begin
              if (c == CH_LBRACE) begin
                phase_d = PH_OPEN;
              end else begin
                phase_d     = PH_FAILED;
                cmd_valid_o = 1'b1;
                cmd_o       = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_BRACE);
              end
            end
          end
          PH_OPEN, PH_AFTER_COMMA: begin
            if (!ws) begin
              if (c == CH_RBRACE && phase_q == PH_OPEN) begin
                phase_d = PH_CLOSED;
              end else if (c == CH_QUOTE) begin
                phase_d = PH_KEY;
              end else begin
                phase_d     = PH_FAILED;
                cmd_valid_o = 1'b1;
                cmd_o       = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_QUOTE);
              end
            end
          end
          PH_KEY, PH_VSTR: begin
            if (c == CH_QUOTE) begin
              phase_d     = (phase_q == PH_KEY) ? PH_AFTER_KEY : PH_AFTER_VAL;
              cmd_valid_o = 1'b1;
              cmd_o = mk(CMD_EMIT, (phase_q == PH_KEY) ? KIND_KEY_END : KIND_PAIR_END,
                         8'h00, ERR_NONE);
            end else if (c == CH_BSLASH) begin
              phase_d = (phase_q == PH_KEY) ? PH_KEY_ESC : PH_VSTR_ESC;
            end else begin
              cmd_valid_o = 1'b1;
              cmd_o = mk(CMD_EMIT, (phase_q == PH_KEY) ? KIND_KEY : KIND_VAL, c, ERR_NONE);
            end
          end
          PH_KEY_ESC, PH_VSTR_ESC: begin
            cmd_valid_o = 1'b1;
            if (esc[8]) begin
              phase_d = PH_FAILED;
              cmd_o   = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_BAD_ESC);
            end else begin
              phase_d = (phase_q == PH_KEY_ESC) ? PH_KEY : PH_VSTR;
              cmd_o = mk(CMD_EMIT, (phase_q == PH_KEY_ESC) ? KIND_KEY : KIND_VAL,
                         esc[7:0], ERR_NONE);
            end
          end
          PH_AFTER_KEY: begin
            if (!ws) begin
              if (c == CH_COLON) begin
                phase_d = PH_BEFORE_VAL;
              end else begin
                phase_d     = PH_FAILED;
                cmd_valid_o = 1'b1;
                cmd_o       = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_COLON);
              end
            end
          end
          PH_BEFORE_VAL: begin
            if (!ws) begin
              cmd_valid_o = 1'b1;
              if (c == CH_QUOTE) begin
                phase_d     = PH_VSTR;
                cmd_valid_o = 1'b0;
              end else if (c == CH_COMMA) begin
                phase_d = PH_AFTER_COMMA;
                cmd_o   = mk(CMD_EMIT, KIND_PAIR_END, 8'h00, ERR_NONE);
              end else if (c == CH_RBRACE) begin
                phase_d = PH_CLOSED;
                cmd_o   = mk(CMD_EMIT, KIND_PAIR_END, 8'h00, ERR_NONE);
              end else begin
                phase_d = PH_BARE;
                cnt_d   = '0;
                cmd_o   = mk(CMD_EMIT, KIND_VAL, c, ERR_NONE);
              end
            end
          end
          PH_AFTER_VAL: begin
            if (!ws) begin
              if (c == CH_COMMA) begin
                phase_d = PH_AFTER_COMMA;
              end else if (c == CH_RBRACE) begin
                phase_d = PH_CLOSED;
              end else begin
                phase_d     = PH_FAILED;
                cmd_valid_o = 1'b1;
                cmd_o       = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_COMMA_BRACE);
              end
            end
          end
          PH_BARE: begin
            cmd_valid_o = 1'b1;
            if (c == CH_COMMA || c == CH_RBRACE) begin
              cnt_d   = '0;
              phase_d = (c == CH_COMMA) ? PH_AFTER_COMMA : PH_CLOSED;
              cmd_o   = mk(CMD_EMIT, KIND_PAIR_END, 8'h00, ERR_NONE);
            end else if (ws) begin
              if (cnt_q >= CW'(WS_PENDING_DEPTH)) begin
                phase_d = PH_FAILED;
                cnt_d   = '0;
                cmd_o   = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_OVERFLOW);
              end else begin
                cnt_d = cnt_q + 1'b1;
                cmd_o = mk(CMD_HOLD, KIND_VAL, c, ERR_NONE);
              end
            end else begin
              cnt_d = '0;
              cmd_o = mk(CMD_DRAIN, KIND_VAL, c, ERR_NONE);
            end
          end
          PH_CLOSED: begin
            if (!ws) begin
              phase_d     = PH_FAILED;
              cmd_valid_o = 1'b1;
              cmd_o       = mk(CMD_EMIT, KIND_REJECT, 8'h00, ERR_TRAILING);
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Phase and held whitespace count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hdl/fjot_cmd_fifo.sv
// Short command queue that decouples the parser from the emitter.
// Depends on fjot_pkg.
module fjot_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fjot_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fjot_pkg::cmd_t data_o
);
  import fjot_pkg::*;

  localparam int unsigned AW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          entries_q [CMD_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == NW'(CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + NW'(do_push) - NW'(do_pop);
    end
  end

  // The parser must never offer a command while the queue is full.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("command pushed into a full queue");

  // The emitter must never take a command from an empty queue.
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("command popped from an empty queue");

  // A transfer in with none out raises the fill level by one.
  a_level_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level out of step");

endmodule

FILE: hdl/fjot_back.sv
// Emitter back end: carries out commands, keeps the held whitespace store and
// drives the result register. Depends on fjot_pkg.
module fjot_back #(
  parameter int unsigned WS_PENDING_DEPTH = fjot_pkg::WS_PENDING_DEPTH_DFLT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  fjot_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output fjot_pkg::fjot_out_t out_item_o
);
  import fjot_pkg::*;

  localparam int unsigned AW = (WS_PENDING_DEPTH > 1) ? $clog2(WS_PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WS_PENDING_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DRAIN
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]    fin_byte_q, fin_byte_d;
  logic          out_vld_q, out_vld_d;
  fjot_out_t     out_q, out_d;
  logic          out_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data_q;
  logic [7:0]    ws_mem [WS_PENDING_DEPTH];

  assign out_free   = !out_vld_q || pop;
  assign empty      = !out_vld_q;
  assign out_item_o = out_q;
  assign wr_addr    = cnt_q[AW-1:0];
  assign rd_addr    = (rd_ptr_d < CW'(WS_PENDING_DEPTH)) ? rd_ptr_d[AW-1:0] : '0;

  // Command execution.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_ptr_d   = rd_ptr_q;
    fin_byte_d = fin_byte_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !pop;
    cmd_pop_o  = 1'b0;
    wr_en      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            CMD_HOLD: begin
              cmd_pop_o = 1'b1;
              wr_en     = 1'b1;
              cnt_d     = cnt_q + 1'b1;
            end
            CMD_EMIT: begin
              if (out_free) begin
                cmd_pop_o         = 1'b1;
                cnt_d             = '0;
                out_vld_d         = 1'b1;
                out_d.kind        = cmd_i.kind;
                out_d.out_byte    = cmd_i.data;
                out_d.error_code  = cmd_i.err;
                out_d.last_of_run = 1'b1;
              end
            end
            CMD_DRAIN: begin
              cmd_pop_o  = 1'b1;
              fin_byte_d = cmd_i.data;
              state_d    = ST_PREP;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      ST_PREP: begin
        // First store read is under way.
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_vld_d        = 1'b1;
          out_d.kind       = KIND_VAL;
          out_d.error_code = ERR_NONE;
          if (rd_ptr_q == cnt_q) begin
            out_d.out_byte    = fin_byte_q;
            out_d.last_of_run = 1'b1;
            cnt_d             = '0;
            rd_ptr_d          = '0;
            state_d           = ST_IDLE;
          end else begin
            out_d.out_byte    = rd_data_q;
            out_d.last_of_run = 1'b0;
            rd_ptr_d          = rd_ptr_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Held whitespace store with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ws_mem[wr_addr] <= cmd_i.data;
    end
    rd_data_q <= ws_mem[rd_addr];
  end

  // Result payload and drain byte.
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    fin_byte_q <= fin_byte_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // The held count never passes the store depth.
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(WS_PENDING_DEPTH)) else $error("held whitespace count overflow");

  // The drain pointer never runs past the held count.
  a_ptr_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= cnt_q) else $error("drain pointer beyond held count");

  // Outside a drain the pointer rests at zero.
  a_ptr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DRAIN) |-> (rd_ptr_q == '0)) else $error("drain pointer not parked");

endmodule

FILE: hdl/flat_json_object_tokenizer_unit.sv
// Top level of the flat object tokenizer: parser front end, command queue and
// emitter back end. Depends on fjot_pkg, fjot_front, fjot_cmd_fifo, fjot_back.
//
//   Channel  Handshake        Payload
//   input    push / full      in_item_i  (operation, data_byte)
//   result   empty / pop      out_item_o (kind, out_byte, error_code, last_of_run)
//
// The parser takes one input item per cycle while the command queue has room.
// The emitter gives one result per cycle while results are taken and no drain
// is being prepared; a result passes the command queue, then the result register.
// Each later byte of an unquoted value first releases all held whitespace bytes.
// Reset clears the parse phase, the queue and the result valid flag at once.
// A stalled result side fills the queue and then raises full.
module flat_json_object_tokenizer_unit #(
  parameter int unsigned WS_PENDING_DEPTH = fjot_pkg::WS_PENDING_DEPTH_DFLT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  fjot_pkg::fjot_in_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output fjot_pkg::fjot_out_t out_item_o
);
  import fjot_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  // Parser.
  fjot_front #(
    .WS_PENDING_DEPTH(WS_PENDING_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .cmd_valid_o(cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // Command queue.
  fjot_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_out)
  );

  // Emitter.
  fjot_back #(
    .WS_PENDING_DEPTH(WS_PENDING_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

FILE: bench/flat_json_object_tokenizer_unit_test.sv
`timescale 1ns / 100ps
// Testbench for flat_json_object_tokenizer_unit: a short scripted payload walk, then random
// flat objects with injected faults, all checked against a behavioural tokenizer written here.
// Depends on fjot_pkg and the flat_json_object_tokenizer_unit RTL.
module flat_json_object_tokenizer_unit_test;
  import fjot_pkg::*;

  localparam int unsigned WS_DEPTH     = WS_PENDING_DEPTH_DFLT;
  localparam int unsigned RANDOM_ITEMS = 275;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 64;

  // Payload characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  // Letters that follow a backslash.
  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_N = 8'h6E;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_T = 8'h74;

  // Where the tokenizer stands within a payload.
  typedef enum logic [3:0] {
    AWAIT_BRACE, AWAIT_KEY_OR_CLOSE, IN_KEY, IN_KEY_ESC, AWAIT_COLON, AWAIT_VALUE,
    IN_STR_VALUE, IN_STR_VALUE_ESC, AWAIT_SEP, IN_BARE_VALUE, AWAIT_KEY, OBJ_CLOSED,
    PAYLOAD_FAILED
  } phase_e;

  // One scripted transfer; kind and err only count where typed is set.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    kind_e      kind;
    err_e       err;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 33;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  fjot_in_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  fjot_out_t out_item;
  bit        calm = 1'b0;

  // Tokenizer state and the results it still expects.
  phase_e      phase = AWAIT_BRACE;
  logic [7:0]  held_space [WS_DEPTH];
  int unsigned held_count = 0;
  fjot_out_t   step_results[$];
  fjot_out_t   pending_results[$];
  fjot_in_t    payload[$];

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned accepts = 0;
  int unsigned rejects = 0;
  int unsigned items_sent = 0;
  int unsigned swallowed = 0;

  script_row_t script_rows [SCRIPT_LEN] = '{
    '{OP_END,  8'h00,     1'b1, KIND_ACCEPT, ERR_NONE},
    '{OP_BYTE, 8'hFF,     1'b1, KIND_REJECT, ERR_BRACE},
    '{OP_BYTE, 8'h00,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_END,  8'hFF,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_LBRACE, 1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, 8'h00,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_BSLASH, 1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_SLASH,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_COLON,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_COMMA,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_COLON,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_SPACE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, 8'h76,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_TAB,    1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_CR,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, 8'hFE,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_SPACE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_RBRACE, 1'b0, KIND_KEY,    ERR_NONE},
    '{OP_END,  8'h00,     1'b1, KIND_ACCEPT, ERR_NONE},
    '{OP_BYTE, CH_LBRACE, 1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_BSLASH, 1'b0, KIND_KEY,    ERR_NONE},
    '{OP_END,  8'h00,     1'b1, KIND_REJECT, ERR_OPEN_ESC},
    '{OP_BYTE, CH_LBRACE, 1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, 8'h6B,     1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_QUOTE,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_BYTE, CH_COLON,  1'b0, KIND_KEY,    ERR_NONE},
    '{OP_END,  8'h00,     1'b1, KIND_REJECT, ERR_COMMA_BRACE}
  };

  logic [7:0] escape_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, ESC_B, ESC_F, ESC_N,
                                     ESC_R, ESC_T};

  flat_json_object_tokenizer_unit #(
    .WS_PENDING_DEPTH(WS_DEPTH)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  // Clock generation.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Decoded byte after a backslash; bit 8 marks an unsupported escape.
  function automatic logic [8:0] unescape(logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: return {1'b0, c};
      ESC_B: return {1'b0, CH_BS};
      ESC_F: return {1'b0, CH_FF};
      ESC_N: return {1'b0, CH_LF};
      ESC_R: return {1'b0, CH_CR};
      ESC_T: return {1'b0, CH_TAB};
      default: return 9'h100;
    endcase
  endfunction

  function automatic void note(kind_e k, logic [7:0] b, err_e e);
    fjot_out_t r;
    r = '{k, b, e, 1'b0};
    step_results = {step_results, r};
  endfunction

  function automatic void reject(err_e e);
    phase = PAYLOAD_FAILED;
    held_count = 0;
    note(KIND_REJECT, 8'h00, e);
  endfunction

  // Advances the tokenizer by one input item and leaves its results in step_results.
  // Returns 1 when the item is a payload byte that a failed payload simply swallows.
  function automatic bit tokenize_step(fjot_in_t item);
    logic [7:0] c;
    logic [8:0] d;
    bit         space;
    phase_e     was;
    c = item.data_byte;
    space = is_space(c);
    was = phase;
    step_results.delete();
    if (item.operation == OP_END) begin
      case (phase)
        AWAIT_BRACE, OBJ_CLOSED:            note(KIND_ACCEPT, 8'h00, ERR_NONE);
        AWAIT_KEY_OR_CLOSE, AWAIT_KEY:      note(KIND_REJECT, 8'h00, ERR_QUOTE);
        IN_KEY, IN_STR_VALUE:               note(KIND_REJECT, 8'h00, ERR_OPEN_STR);
        IN_KEY_ESC, IN_STR_VALUE_ESC:       note(KIND_REJECT, 8'h00, ERR_OPEN_ESC);
        AWAIT_COLON:                        note(KIND_REJECT, 8'h00, ERR_COLON);
        AWAIT_VALUE, AWAIT_SEP, IN_BARE_VALUE: note(KIND_REJECT, 8'h00, ERR_COMMA_BRACE);
        default: ;
      endcase
      phase = AWAIT_BRACE;
      held_count = 0;
    end else begin
      case (phase)
        AWAIT_BRACE: begin
          if (c == CH_LBRACE) phase = AWAIT_KEY_OR_CLOSE;
          else if (!space) reject(ERR_BRACE);
        end
        AWAIT_KEY_OR_CLOSE: begin
          if (c == CH_RBRACE) phase = OBJ_CLOSED;
          else if (c == CH_QUOTE) phase = IN_KEY;
          else if (!space) reject(ERR_QUOTE);
        end
        AWAIT_KEY: begin
          if (c == CH_QUOTE) phase = IN_KEY;
          else if (!space) reject(ERR_QUOTE);
        end
        IN_KEY: begin
          if (c == CH_QUOTE) begin
            phase = AWAIT_COLON;
            note(KIND_KEY_END, 8'h00, ERR_NONE);
          end else if (c == CH_BSLASH) begin
            phase = IN_KEY_ESC;
          end else begin
            note(KIND_KEY, c, ERR_NONE);
          end
        end
        IN_KEY_ESC, IN_STR_VALUE_ESC: begin
          d = unescape(c);
          if (d[8]) begin
            reject(ERR_BAD_ESC);
          end else if (phase == IN_KEY_ESC) begin
            note(KIND_KEY, d[7:0], ERR_NONE);
            phase = IN_KEY;
          end else begin
            note(KIND_VAL, d[7:0], ERR_NONE);
            phase = IN_STR_VALUE;
          end
        end
        AWAIT_COLON: begin
          if (c == CH_COLON) phase = AWAIT_VALUE;
          else if (!space) reject(ERR_COLON);
        end
        AWAIT_VALUE: begin
          if (space) begin
            // Leading whitespace before a value is skipped.
          end else if (c == CH_QUOTE) begin
            phase = IN_STR_VALUE;
          end else if (c == CH_COMMA || c == CH_RBRACE) begin
            phase = (c == CH_COMMA) ? AWAIT_KEY : OBJ_CLOSED;
            note(KIND_PAIR_END, 8'h00, ERR_NONE);
          end else begin
            phase = IN_BARE_VALUE;
            held_count = 0;
            note(KIND_VAL, c, ERR_NONE);
          end
        end
        IN_STR_VALUE: begin
          if (c == CH_QUOTE) begin
            phase = AWAIT_SEP;
            note(KIND_PAIR_END, 8'h00, ERR_NONE);
          end else if (c == CH_BSLASH) begin
            phase = IN_STR_VALUE_ESC;
          end else begin
            note(KIND_VAL, c, ERR_NONE);
          end
        end
        AWAIT_SEP: begin
          if (c == CH_COMMA) phase = AWAIT_KEY;
          else if (c == CH_RBRACE) phase = OBJ_CLOSED;
          else if (!space) reject(ERR_COMMA_BRACE);
        end
        IN_BARE_VALUE: begin
          // Whitespace is held back and only released ahead of a further value byte.
          if (c == CH_COMMA || c == CH_RBRACE) begin
            held_count = 0;
            phase = (c == CH_COMMA) ? AWAIT_KEY : OBJ_CLOSED;
            note(KIND_PAIR_END, 8'h00, ERR_NONE);
          end else if (space) begin
            if (held_count >= WS_DEPTH) begin
              reject(ERR_OVERFLOW);
            end else begin
              held_space[held_count] = c;
              held_count++;
            end
          end else begin
            for (int unsigned i = 0; i < held_count; i++) note(KIND_VAL, held_space[i], ERR_NONE);
            held_count = 0;
            note(KIND_VAL, c, ERR_NONE);
          end
        end
        OBJ_CLOSED: begin
          if (!space) reject(ERR_TRAILING);
        end
        default: ;
      endcase
    end
    if (step_results.size() != 0) begin
      step_results[step_results.size() - 1].last_of_run = 1'b1;
    end
    return item.operation == OP_BYTE && was == PAYLOAD_FAILED;
  endfunction

  // Payload building blocks for the random part.
  function automatic void put_byte(logic [7:0] b);
    fjot_in_t t;
    t = '{OP_BYTE, b};
    payload = {payload, t};
  endfunction

  function automatic void put_spaces(int unsigned n);
    int unsigned k;
    repeat (n) begin
      k = $urandom_range(0, 5);
      put_byte((k == 5) ? CH_SPACE : CH_TAB + 8'(k));
    end
  endfunction

  // Quoted body: mostly plain bytes, with valid escapes and the odd broken one.
  function automatic void put_string_body(int unsigned len);
    logic [7:0] b;
    repeat (len) begin
      if ($urandom_range(99) < 15) begin
        put_byte(CH_BSLASH);
        if ($urandom_range(99) < 8) put_byte(8'($urandom_range(255)));
        else put_byte(escape_letters[$urandom_range(0, 7)]);
      end else begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        put_byte(b);
      end
    end
  endfunction

  function automatic logic [7:0] bare_byte(bit opening);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (is_space(b) || b == CH_COMMA || b == CH_RBRACE || (opening && b == CH_QUOTE));
    return b;
  endfunction

  // Unquoted value with whitespace runs inside, a few of them near the held limit.
  function automatic void put_bare(int unsigned long_run);
    int unsigned segs;
    segs = (long_run != 0) ? 1 + $urandom_range(0, 1) : $urandom_range(0, 2);
    put_byte(bare_byte(1'b1));
    for (int unsigned s = 0; s < segs; s++) begin
      if (s == 0 && long_run != 0) put_spaces(long_run);
      else if ($urandom_range(99) < 15) put_spaces($urandom_range(28, 34));
      else put_spaces($urandom_range(0, 3));
      repeat ($urandom_range(1, 3)) put_byte(bare_byte(1'b0));
    end
    put_spaces($urandom_range(0, 3));
  endfunction

  // One payload and its end marker. The first two carry a full and an overfull held run.
  function automatic void build_payload(int unsigned serial);
    int unsigned mode, pairs, pick, pos, long_run;
    fjot_in_t    marker;
    payload.delete();
    long_run = (serial == 0) ? WS_DEPTH : (serial == 1) ? WS_DEPTH + 1 : 0;
    mode = (long_run != 0) ? 99 : $urandom_range(99);
    if (mode < 6) begin
      put_spaces($urandom_range(0, 3));
    end else if (mode < 12) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(255)));
    end else begin
      put_spaces($urandom_range(0, 2));
      put_byte(CH_LBRACE);
      pairs = (long_run != 0) ? 1 : $urandom_range(0, 4);
      for (int unsigned p = 0; p < pairs; p++) begin
        put_spaces($urandom_range(0, 1));
        put_byte(CH_QUOTE);
        put_string_body($urandom_range(0, 5));
        put_byte(CH_QUOTE);
        put_spaces($urandom_range(0, 1));
        put_byte(CH_COLON);
        put_spaces($urandom_range(0, 1));
        pick = (long_run != 0) ? 50 : $urandom_range(99);
        if (pick < 45) begin
          put_byte(CH_QUOTE);
          put_string_body($urandom_range(0, 6));
          put_byte(CH_QUOTE);
        end else if (pick < 88) begin
          put_bare(long_run);
        end
        put_spaces($urandom_range(0, 1));
        put_byte((p == pairs - 1) ? CH_RBRACE : CH_COMMA);
      end
      if (pairs == 0) put_byte(CH_RBRACE);
      put_spaces($urandom_range(0, 2));
    end
    // Fault injection: a wrong byte, an early end marker or trailing junk.
    if (long_run == 0 && payload.size() != 0 && $urandom_range(99) < 22) begin
      pos = $urandom_range(0, payload.size() - 1);
      case ($urandom_range(0, 2))
        0: payload[pos].data_byte = 8'($urandom_range(255));
        1: while (payload.size() > pos) void'(payload.pop_back());
        default: put_byte(8'($urandom_range(255)));
      endcase
    end
    marker = '{OP_END, 8'($urandom_range(255))};
    payload = {payload, marker};
  endfunction

  // One input transfer, with random idle cycles ahead of it; records what it should cause.
  task automatic deliver(input fjot_in_t item, input bit typed, input fjot_out_t typed_result,
                         output bit ignored);
    while (!calm && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    ignored = tokenize_step(item);
    if (typed) pending_results = {pending_results, typed_result};
    else pending_results = {pending_results, step_results};
  endtask

  // Result side: random stalls, and each result transfer compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    fjot_out_t want;
    if (rst_ni && pop && !empty) begin
      results_checked++;
      if (out_item.kind == KIND_ACCEPT) accepts++;
      if (out_item.kind == KIND_REJECT) rejects++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, actual kind %0d byte %02h err %0d last %0b", $time,
                 out_item.kind, out_item.out_byte, out_item.error_code, out_item.last_of_run);
      end else begin
        want = pending_results.pop_front();
        if (out_item.kind != want.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d, actual %0d", $time, want.kind, out_item.kind);
        end
        if (out_item.out_byte != want.out_byte) begin
          mismatches++;
          $display("%0t: byte expected %02h, actual %02h", $time, want.out_byte,
                   out_item.out_byte);
        end
        if (out_item.error_code != want.error_code) begin
          mismatches++;
          $display("%0t: error code expected %0d, actual %0d", $time, want.error_code,
                   out_item.error_code);
        end
        if (out_item.last_of_run != want.last_of_run) begin
          mismatches++;
          $display("%0t: last flag expected %0b, actual %0b", $time, want.last_of_run,
                   out_item.last_of_run);
        end
      end
    end
    pop <= calm || ($urandom_range(99) >= 37);
  end

  // Stimulus: scripted walk, random payloads, then drain and verdict.
  initial begin : stimulus
    int unsigned counted;
    int unsigned serial;
    bit          paused;
    bit          ignored;
    counted = 0;
    serial = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_rows[r])
      deliver('{script_rows[r].op, script_rows[r].data}, script_rows[r].typed,
              '{script_rows[r].kind, 8'h00, script_rows[r].err, 1'b1}, ignored);

    while (counted < RANDOM_ITEMS) begin
      // A stretch with no idling on either side.
      calm <= (counted >= 60 && counted < 140);
      // Once, hold the input back until every expected result has come out.
      if (!paused && counted >= 150) begin
        paused = 1'b1;
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      build_payload(serial);
      serial++;
      foreach (payload[i]) begin
        deliver(payload[i], 1'b0, '0, ignored);
        counted++;
        if (ignored) swallowed++;
      end
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Drove %0d input items (%0d swallowed after a reject): %0d scripted, %0d payloads.",
             items_sent, swallowed, SCRIPT_LEN, serial);
    $display("Checked %0d results: %0d payloads accepted, %0d rejected; %0d mismatches.",
             results_checked, accepts, rejects, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Cycle limit for a hung handshake.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
             pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
